// File: hdl/wtlm_pkg.sv
`default_nettype none
package wtlm_pkg;

    // Width of the line number as it appears on the result channel.
    localparam int unsigned LN_W = 20;

    // Depth of the queue between the front and back parts.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;

    // Character codes the classifier looks for.
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_VT    = 8'h0B;
    localparam logic [7:0] C_FF    = 8'h0C;
    localparam logic [7:0] C_HASH  = 8'h23;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NINE  = 8'h39;

    typedef enum logic [1:0] {
        K_CHAR    = 2'd0,
        K_TEND    = 2'd1,
        K_NEWLINE = 2'd2,
        K_EOI     = 2'd3
    } t_kind;

    // One queue entry: the one or two results that one item causes.
    // The second result is always a newline token or end of input.
    typedef struct packed {
        logic              two;
        t_kind             kind0;
        logic [7:0]        char0;
        logic [LN_W-1:0]   line0;
        logic              trunc0;
        t_kind             kind1;
        logic [LN_W-1:0]   line1;
    } t_cmd;

endpackage
`default_nettype wire

// File: hdl/wtlm_if.sv
`default_nettype none
interface wtlm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_end;

    modport source (output valid, output in_byte, output is_end, input ready);
    modport sink   (input valid, input in_byte, input is_end, output ready);
endinterface

interface wtlm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_char;
    logic [19:0] line_number;
    logic        truncated;
    logic        last;

    modport source (output valid, output kind, output out_char, output line_number,
                    output truncated, output last, input ready);
    modport sink   (input valid, input kind, input out_char, input line_number,
                    input truncated, input last, output ready);
endinterface
`default_nettype wire

// File: hdl/whitespace_tokenizer_line_markers_top.sv
`default_nettype none
// Channel   Role    Handshake      Payload
// i_in      sink    valid/ready    in_byte[7:0], is_end
// o_out     source  valid/ready    kind[1:0], out_char[7:0], line_number[19:0],
//                                  truncated, last
//
// One byte is accepted per cycle while the result queue has room; the front classifies
// it and updates the tokenizer state at that same edge. Its results are queued and
// then registered in the back part before they reach o_out. The back part hands out
// one result per cycle while o_out is ready, so items with two results halve the rate
// once the four-entry queue is full. Reset is synchronous and active low; the line
// counter returns to 1. A stall on o_out fills the queue and then holds i_in.ready low.
module whitespace_tokenizer_line_markers_top import wtlm_pkg::*; #(
    parameter int unsigned MAX_TOKEN = 255,
    parameter int unsigned LINE_BITS = 20
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wtlm_in_if.sink     i_in,
    wtlm_out_if.source  o_out
);

    logic q_full;
    logic take;
    logic push;
    t_cmd push_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    // The input is ready whenever the queue can take a new entry, so a
    // finished result waiting on the output never blocks the next byte by itself.
    assign i_in.ready = !q_full;
    assign take       = i_in.valid && !q_full;

    // The front part holds all tokenizer state and turns each item into a queue entry.
    wtlm_front #(
        .MAX_TOKEN (MAX_TOKEN),
        .LINE_BITS (LINE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_in_byte (i_in.in_byte),
        .i_is_end  (i_in.is_end),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    // Short queue that decouples classification from result delivery.
    wtlm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take && push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // The back part unpacks each entry into one or two results.
    wtlm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_kind        (o_out.kind),
        .o_out_char    (o_out.out_char),
        .o_line_number (o_out.line_number),
        .o_truncated   (o_out.truncated),
        .o_last        (o_out.last)
    );

    // End of input is always the final result of its item.
    a_eoi_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == K_EOI)) |-> o_out.last)
        else $error("end of input result not marked last");

    // Only a token end can carry the truncation flag.
    a_trunc_tend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.truncated) |-> (o_out.kind == K_TEND))
        else $error("truncated flag on a result that is not a token end");

    // A token end is never the last result when the queue entry carries a second one
    // that is a newline; a newline token always stands last.
    a_newline_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == K_NEWLINE)) |-> o_out.last)
        else $error("newline token not marked last");

    // The queue never accepts an entry while full.
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !take)
        else $error("item accepted while the result queue is full");

endmodule
`default_nettype wire

// File: hdl/wtlm_front.sv
`default_nettype none
module wtlm_front import wtlm_pkg::*; #(
    parameter int unsigned MAX_TOKEN = 255,
    parameter int unsigned LINE_BITS = 20
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_is_end,
    output      logic       o_push,
    output      t_cmd       o_cmd
);

    localparam int unsigned LEN_W = $clog2(MAX_TOKEN + 1);
    localparam int unsigned AW    = LINE_BITS + 4;
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    typedef enum logic [5:0] {
        M_BETWEEN = 6'b000001,
        M_TOKEN   = 6'b000010,
        M_LEAD    = 6'b000100,
        M_DIGITS  = 6'b001000,
        M_SKIP    = 6'b010000,
        M_ENDED   = 6'b100000
    } t_mode;

    t_mode                r_mode, n_mode;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic [LINE_BITS-1:0] r_acc, n_acc;
    logic                 r_neg, n_neg;
    logic [LEN_W-1:0]     r_len, n_len;
    logic                 r_ov, n_ov;

    logic                 is_sep, is_lf, is_hash, is_digit, is_lead_ws, is_sign;
    logic [3:0]           dig;
    logic [AW-1:0]        acc_wide;
    logic [LINE_BITS-1:0] acc_sat, line_inc, line_load;

    assign is_sep     = (i_in_byte == C_SPACE) || (i_in_byte == C_TAB) || (i_in_byte == C_CR);
    assign is_lf      = (i_in_byte == C_LF);
    assign is_hash    = (i_in_byte == C_HASH);
    assign is_digit   = (i_in_byte >= C_ZERO) && (i_in_byte <= C_NINE);
    assign is_lead_ws = is_sep || (i_in_byte == C_VT) || (i_in_byte == C_FF);
    assign is_sign    = (i_in_byte == C_PLUS) || (i_in_byte == C_MINUS);
    assign dig        = 4'(i_in_byte - C_ZERO);

    // acc * 10 + digit, saturated at the top line value.
    assign acc_wide  = (AW'(r_acc) << 3) + (AW'(r_acc) << 1) + AW'(dig);
    assign acc_sat   = (acc_wide > AW'(LINE_MAX)) ? LINE_MAX : acc_wide[LINE_BITS-1:0];
    assign line_inc  = (r_line == LINE_MAX) ? r_line : r_line + LINE_BITS'(1);
    assign line_load = (r_neg && (r_acc != '0)) ? '0 : r_acc;

    always_comb begin
        n_mode = r_mode;
        n_line = r_line;
        n_acc  = r_acc;
        n_neg  = r_neg;
        n_len  = r_len;
        n_ov   = r_ov;
        o_push = 1'b0;
        o_cmd  = '{two: 1'b0, kind0: K_CHAR, char0: 8'h00, line0: LN_W'(r_line),
                   trunc0: 1'b0, kind1: K_EOI, line1: LN_W'(r_line)};

        if (r_mode == M_ENDED) begin
            o_push      = 1'b1;
            o_cmd.kind0 = K_EOI;
        end else if (i_is_end) begin
            o_push = 1'b1;
            if (r_mode == M_TOKEN) begin
                o_cmd.two    = 1'b1;
                o_cmd.kind0  = K_TEND;
                o_cmd.trunc0 = r_ov;
            end else begin
                o_cmd.kind0 = K_EOI;
            end
            n_mode = M_ENDED;
            n_len  = '0;
            n_ov   = 1'b0;
            n_acc  = '0;
            n_neg  = 1'b0;
        end else begin
            case (r_mode)
                M_TOKEN: begin
                    if (is_sep || is_lf || is_hash) begin
                        o_push       = 1'b1;
                        o_cmd.kind0  = K_TEND;
                        o_cmd.trunc0 = r_ov;
                        n_len        = '0;
                        n_ov         = 1'b0;
                        n_mode       = M_BETWEEN;
                        if (is_lf) begin
                            n_line      = line_inc;
                            o_cmd.two   = 1'b1;
                            o_cmd.kind1 = K_NEWLINE;
                            o_cmd.line1 = LN_W'(line_inc);
                        end else if (is_hash) begin
                            n_mode = M_LEAD;
                            n_acc  = '0;
                            n_neg  = 1'b0;
                        end
                    end else if (r_len < LEN_W'(MAX_TOKEN)) begin
                        n_len       = r_len + LEN_W'(1);
                        o_push      = 1'b1;
                        o_cmd.char0 = i_in_byte;
                    end else begin
                        n_ov = 1'b1;
                    end
                end
                M_LEAD, M_DIGITS, M_SKIP: begin
                    if (is_lf) begin
                        n_line      = line_load;
                        n_acc       = '0;
                        n_neg       = 1'b0;
                        n_mode      = M_BETWEEN;
                        o_push      = 1'b1;
                        o_cmd.kind0 = K_NEWLINE;
                        o_cmd.line0 = LN_W'(line_load);
                    end else if (is_digit && (r_mode != M_SKIP)) begin
                        n_acc  = acc_sat;
                        n_mode = M_DIGITS;
                    end else if ((r_mode == M_LEAD) && is_lead_ws) begin
                        n_mode = M_LEAD;
                    end else if ((r_mode == M_LEAD) && is_sign) begin
                        n_neg  = (i_in_byte == C_MINUS);
                        n_mode = M_DIGITS;
                    end else begin
                        n_mode = M_SKIP;
                    end
                end
                default: begin
                    if (is_lf) begin
                        n_line      = line_inc;
                        o_push      = 1'b1;
                        o_cmd.kind0 = K_NEWLINE;
                        o_cmd.line0 = LN_W'(line_inc);
                    end else if (is_hash) begin
                        n_mode = M_LEAD;
                        n_acc  = '0;
                        n_neg  = 1'b0;
                    end else if (!is_sep) begin
                        n_mode      = M_TOKEN;
                        n_len       = LEN_W'(1);
                        n_ov        = 1'b0;
                        o_push      = 1'b1;
                        o_cmd.char0 = i_in_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_BETWEEN;
            r_line <= LINE_BITS'(1);
            r_acc  <= '0;
            r_neg  <= 1'b0;
            r_len  <= '0;
            r_ov   <= 1'b0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_acc  <= n_acc;
            r_neg  <= n_neg;
            r_len  <= n_len;
            r_ov   <= n_ov;
        end
    end

endmodule
`default_nettype wire

// File: hdl/wtlm_queue.sv
`default_nettype none
module wtlm_queue import wtlm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output      logic o_full,
    input  wire logic i_pop,
    output      logic o_valid,
    output      t_cmd o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (QPTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (QPTR_W+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/wtlm_back.sv
`default_nettype none
module wtlm_back import wtlm_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire t_cmd            i_q_cmd,
    output      logic            o_q_pop,
    output      logic            o_valid,
    input  wire logic            i_ready,
    output      logic [1:0]      o_kind,
    output      logic [7:0]      o_out_char,
    output      logic [LN_W-1:0] o_line_number,
    output      logic            o_truncated,
    output      logic            o_last
);

    logic r_valid;
    logic r_sel;
    t_cmd r_cmd;
    logic done_one, finishing;

    assign done_one  = r_valid && i_ready;
    assign finishing = done_one && (r_sel || !r_cmd.two);
    assign o_q_pop   = (!r_valid || finishing) && i_q_valid;

    assign o_valid       = r_valid;
    assign o_kind        = r_sel ? r_cmd.kind1 : r_cmd.kind0;
    assign o_out_char    = r_sel ? 8'h00 : r_cmd.char0;
    assign o_line_number = r_sel ? r_cmd.line1 : r_cmd.line0;
    assign o_truncated   = r_sel ? 1'b0 : r_cmd.trunc0;
    assign o_last        = r_sel || !r_cmd.two;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
            r_sel   <= 1'b0;
        end else if (finishing) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (done_one) begin
            r_sel <= 1'b1;
        end
    end

endmodule
`default_nettype wire

// File: test/whitespace_tokenizer_line_markers_top_tb.sv
`timescale 1ns / 1ps
module whitespace_tokenizer_line_markers_top_tb;
    import wtlm_pkg::*;

    // The block is built with its default sizes, and the tokenizer model below
    // uses the same ones.
    localparam int unsigned TOK_MAX      = 255;
    localparam logic [LN_W-1:0] LINE_TOP = '1;

    // The watchdog ends the run after this many cycles in which neither channel
    // moves an item. The longest legal quiet stretch is the receiver hold-off.
    localparam int unsigned QUIET_LIMIT  = 3000;
    localparam int unsigned LONG_STALL   = 400;
    localparam int unsigned PHASE_ITEMS  = 460;
    localparam int unsigned DRAIN_CYCLES = 20;

    // Scanner state of the tokenizer model.
    typedef enum logic [5:0] {
        SCAN_BETWEEN = 6'b000001,
        SCAN_TOKEN   = 6'b000010,
        SCAN_LEAD    = 6'b000100,
        SCAN_DIGITS  = 6'b001000,
        SCAN_SKIP    = 6'b010000,
        SCAN_ENDED   = 6'b100000
    } t_scan_mode;

    // One result as it appears on the output channel.
    typedef struct packed {
        t_kind           kind;
        logic [7:0]      ch;
        logic [LN_W-1:0] line;
        logic            trunc;
        logic            last;
    } t_tok_result;

    // The scoreboard runs the tokenizer model on every accepted input item and
    // keeps the results it predicts in order, oldest first. Every accepted
    // output item is compared against the oldest prediction.
    class token_scoreboard;
        t_scan_mode      mode;
        logic [LN_W-1:0] line_count;
        logic [LN_W-1:0] number_acc;
        bit              number_neg;
        int unsigned     tok_len;
        bit              tok_over;
        t_tok_result     step_results[$];
        t_tok_result     predicted_stream[$];
        int unsigned     mismatches;
        int unsigned     results_checked;
        int unsigned     items_taken;
        int unsigned     kind_count[4];

        function new();
            mode       = SCAN_BETWEEN;
            line_count = 1;
            number_acc = '0;
            number_neg = 1'b0;
            tok_len    = 0;
            tok_over   = 1'b0;
            mismatches = 0;
            results_checked = 0;
            items_taken = 0;
            foreach (kind_count[i]) kind_count[i] = 0;
        endfunction

        function void emit(t_kind k, logic [7:0] c, bit t);
            t_tok_result r;
            r.kind  = k;
            r.ch    = (k == K_CHAR) ? c : 8'h00;
            r.line  = line_count;
            r.trunc = t;
            r.last  = 1'b0;
            step_results.push_back(r);
            kind_count[k]++;
        endfunction

        function void bump_line();
            if (line_count != LINE_TOP) line_count++;
        endfunction

        function void open_directive();
            mode       = SCAN_LEAD;
            number_acc = '0;
            number_neg = 1'b0;
        endfunction

        // Predicts the results of one accepted input item.
        function void tokenize_byte(logic [7:0] c, logic e);
            int unsigned grown;
            bit          is_sep;
            bit          in_directive;
            step_results.delete();
            items_taken++;
            is_sep       = (c == C_SPACE) || (c == C_TAB) || (c == C_CR);
            in_directive = (mode == SCAN_LEAD) || (mode == SCAN_DIGITS) || (mode == SCAN_SKIP);
            if (mode == SCAN_ENDED) begin
                emit(K_EOI, 8'h00, 1'b0);
            end else if (e) begin
                if (mode == SCAN_TOKEN) emit(K_TEND, 8'h00, tok_over);
                mode       = SCAN_ENDED;
                tok_len    = 0;
                tok_over   = 1'b0;
                number_acc = '0;
                number_neg = 1'b0;
                emit(K_EOI, 8'h00, 1'b0);
            end else if (mode == SCAN_TOKEN) begin
                if (is_sep || c == C_LF || c == C_HASH) begin
                    emit(K_TEND, 8'h00, tok_over);
                    tok_len  = 0;
                    tok_over = 1'b0;
                    mode     = SCAN_BETWEEN;
                    if (c == C_LF) begin
                        bump_line();
                        emit(K_NEWLINE, 8'h00, 1'b0);
                    end else if (c == C_HASH) begin
                        open_directive();
                    end
                end else if (tok_len < TOK_MAX) begin
                    tok_len++;
                    emit(K_CHAR, c, 1'b0);
                end else begin
                    tok_over = 1'b1;
                end
            end else if (in_directive) begin
                if (c == C_LF) begin
                    if (number_neg && number_acc != 0) line_count = '0;
                    else line_count = number_acc;
                    number_acc = '0;
                    number_neg = 1'b0;
                    mode       = SCAN_BETWEEN;
                    emit(K_NEWLINE, 8'h00, 1'b0);
                end else if (c >= C_ZERO && c <= C_NINE && mode != SCAN_SKIP) begin
                    grown = 32'(number_acc) * 10 + 32'(c) - 32'(C_ZERO);
                    number_acc = (grown > 32'(LINE_TOP)) ? LINE_TOP : grown[LN_W-1:0];
                    mode = SCAN_DIGITS;
                end else if (mode == SCAN_LEAD && (is_sep || c == C_VT || c == C_FF)) begin
                    // Leading white space before the number is skipped.
                end else if (mode == SCAN_LEAD && (c == C_PLUS || c == C_MINUS)) begin
                    number_neg = (c == C_MINUS);
                    mode       = SCAN_DIGITS;
                end else begin
                    mode = SCAN_SKIP;
                end
            end else begin
                if (is_sep) begin
                    // Separators between tokens give nothing.
                end else if (c == C_LF) begin
                    bump_line();
                    emit(K_NEWLINE, 8'h00, 1'b0);
                end else if (c == C_HASH) begin
                    open_directive();
                end else begin
                    mode     = SCAN_TOKEN;
                    tok_len  = 1;
                    tok_over = 1'b0;
                    emit(K_CHAR, c, 1'b0);
                end
            end
            if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
            foreach (step_results[i]) predicted_stream.push_back(step_results[i]);
        endfunction

        // Compares one accepted output item with the oldest prediction.
        function void check_result(t_tok_result got);
            t_tok_result want;
            results_checked++;
            if (predicted_stream.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing predicted: kind %0d char %02h line %0d",
                             got.kind, got.ch, got.line);
            end else begin
                want = predicted_stream.pop_front();
                if (got.kind !== want.kind || got.ch !== want.ch || got.line !== want.line ||
                    got.trunc !== want.trunc || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: #%0d want kind %0d ch %02h line %0d tr %0b last %0b",
                                 results_checked, want.kind, want.ch, want.line, want.trunc,
                                 want.last);
                        $display("       got  kind %0d ch %02h line %0d tr %0b last %0b",
                                 got.kind, got.ch, got.line, got.trunc, got.last);
                    end
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    wtlm_in_if  in_ch ();
    wtlm_out_if out_ch ();

    whitespace_tokenizer_line_markers_top #(
        .MAX_TOKEN (TOK_MAX),
        .LINE_BITS (LN_W)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    token_scoreboard sb = new();

    // Idle percentages for the two sides; the stimulus process changes them per phase.
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    // Set by the stimulus process to ask the receiver for one long hold-off.
    bit          long_stall_req = 1'b0;
    int unsigned items_sent = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Both channels are sampled in this one process at the rising edge, so an
    // input item is always noted before any output of the same edge is checked.
    always @(posedge i_clk) begin : monitor
        t_tok_result got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) sb.tokenize_byte(in_ch.in_byte, in_ch.is_end);
            if (out_ch.valid && out_ch.ready) begin
                got.kind  = t_kind'(out_ch.kind);
                got.ch    = out_ch.out_char;
                got.line  = out_ch.line_number;
                got.trunc = out_ch.truncated;
                got.last  = out_ch.last;
                sb.check_result(got);
            end
        end
    end

    // The watchdog counts cycles in which no item moves on either channel.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("ERROR: no item moved for %0d cycles", QUIET_LIMIT);
        $display("whitespace_tokenizer_line_markers_top regression: fail");
        $finish;
    end

    // The receiver drops ready at random, and holds it low for a long stretch
    // once when asked, so that the result queue fills and the input stalls.
    initial begin : result_sink
        int unsigned hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_stall_req) begin
                hold = LONG_STALL;
                long_stall_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Offers one item, with random idle cycles first, and returns at the falling
    // edge after the item was accepted. Valid stays high into the next item
    // unless that one starts with an idle cycle.
    task automatic send_item(input logic [7:0] b, input logic e);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.is_end  <= e;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    // A byte that the tokenizer takes as a token character. Most are printable,
    // a quarter come from the whole byte range.
    function automatic logic [7:0] ordinary_byte();
        logic [7:0] b;
        do begin
            b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(33, 126));
        end while (b == C_SPACE || b == C_TAB || b == C_CR || b == C_LF || b == C_HASH);
        return b;
    endfunction

    function automatic logic [7:0] separator_byte();
        case ($urandom_range(2))
            0:       return C_SPACE;
            1:       return C_TAB;
            default: return C_CR;
        endcase
    endfunction

    task automatic send_token(input int unsigned len);
        repeat (len) send_item(ordinary_byte(), 1'b0);
    endtask

    // A line-marker directive: '#', optional leading white space, optional sign,
    // digits, and a tail such as a quoted file name or junk, closed by a newline.
    // Some directives start with junk so that the number is never read.
    task automatic send_directive();
        int unsigned n_digits;
        send_item(C_HASH, 1'b0);
        repeat ($urandom_range(2)) begin
            case ($urandom_range(4))
                0: send_item(C_SPACE, 1'b0);
                1: send_item(C_TAB, 1'b0);
                2: send_item(C_CR, 1'b0);
                3: send_item(C_VT, 1'b0);
                default: send_item(C_FF, 1'b0);
            endcase
        end
        if ($urandom_range(9) == 0) send_item(8'($urandom_range(97, 122)), 1'b0);
        case ($urandom_range(3))
            1: send_item(C_PLUS, 1'b0);
            2: send_item(C_MINUS, 1'b0);
            default: ;
        endcase
        // Mostly short numbers; now and then one long enough to saturate.
        n_digits = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
        repeat (n_digits) send_item(8'(C_ZERO + $urandom_range(9)), 1'b0);
        case ($urandom_range(2))
            1: send_text(" \"src/lex.c\" 2");
            2: begin
                repeat ($urandom_range(1, 4)) begin
                    logic [7:0] junk;
                    junk = 8'($urandom_range(255));
                    if (junk == C_LF) junk = C_HASH;
                    send_item(junk, 1'b0);
                end
            end
            default: ;
        endcase
        send_item(C_LF, 1'b0);
    endtask

    // A text line of a few short tokens. Now and then the last token runs
    // straight into a directive.
    task automatic send_line();
        int unsigned n_tokens;
        n_tokens = $urandom_range(0, 5);
        for (int t = 0; t < n_tokens; t++) begin
            if (t > 0 || $urandom_range(1) == 0)
                repeat ($urandom_range(1, 3)) send_item(separator_byte(), 1'b0);
            send_token($urandom_range(1, 8));
        end
        if (n_tokens > 0 && $urandom_range(9) == 0) begin
            send_directive();
        end else begin
            repeat ($urandom_range(0, 1)) send_item(separator_byte(), 1'b0);
            send_item(C_LF, 1'b0);
        end
    endtask

    // Mostly well-formed text and directives; the rest is raw byte noise.
    task automatic random_traffic(input int unsigned quota);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 60) send_line();
            else if (pick < 85) send_directive();
            else repeat ($urandom_range(1, 8)) send_item(8'($urandom_range(255)), 1'b0);
        end
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.is_end  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase one: the sender idles now and then, the receiver often.
        src_idle_pct = 29;
        snk_idle_pct = 60;

        // Directed cases. A token of the extreme byte values, ended by a tab.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(C_TAB, 1'b0);
        // A newline ends a token and advances the line.
        send_text("x\n");
        // A '#' ends a token and opens a directive; a negative number loads 0.
        send_text("y#-5\n");
        // A newline after a loaded zero.
        send_item(C_LF, 1'b0);
        // Vertical tab before a signed number too large for the counter.
        send_item(C_HASH, 1'b0);
        send_item(C_VT, 1'b0);
        send_text("+9999999\n");
        // The saturated counter does not wrap on a newline.
        send_item(C_LF, 1'b0);
        // A directive with no digits loads 0.
        send_text("#\n");
        // Separators between tokens give nothing.
        send_text(" \r");

        // A token at exactly the length limit, not truncated.
        send_token(TOK_MAX);
        send_item(C_LF, 1'b0);
        random_traffic(PHASE_ITEMS - TOK_MAX);

        // Phase two: roles swapped, with a token one character over the limit.
        // The newline first closes whatever the random traffic left open.
        src_idle_pct = 60;
        snk_idle_pct = 29;
        send_item(C_LF, 1'b0);
        send_token(TOK_MAX + 1);
        send_item(separator_byte(), 1'b0);
        random_traffic(PHASE_ITEMS - TOK_MAX);

        // Phase three: no idling, except one long receiver hold-off while the
        // sender keeps offering, which fills the block and stalls its input.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        long_stall_req = 1'b1;
        random_traffic(PHASE_ITEMS);

        // End of input from one of three states: inside a token, inside a
        // directive, or between tokens. Later items give only end markers.
        case ($urandom_range(2))
            0: send_token($urandom_range(1, 4));
            1: begin
                send_item(C_HASH, 1'b0);
                send_text(" 42");
            end
            default: send_item(C_LF, 1'b0);
        endcase
        send_item(8'($urandom_range(255)), 1'b1);
        repeat (6) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
        in_ch.valid <= 1'b0;

        while (sb.predicted_stream.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.predicted_stream.size() != 0)
            $display("ERROR: %0d predicted results never arrived", sb.predicted_stream.size());
        $display("Covered %0d input items and %0d results: %0d characters, %0d token ends,",
                 sb.items_taken, sb.results_checked, sb.kind_count[K_CHAR],
                 sb.kind_count[K_TEND]);
        $display("%0d newlines, %0d end markers, three idle mixes and a %0d-cycle output stall.",
                 sb.kind_count[K_NEWLINE], sb.kind_count[K_EOI], LONG_STALL);
        if (sb.mismatches == 0 && sb.predicted_stream.size() == 0) begin
            $display("whitespace_tokenizer_line_markers_top regression: pass");
        end else begin
            $display("%0d mismatches in total", sb.mismatches);
            $display("whitespace_tokenizer_line_markers_top regression: fail");
        end
        $finish;
    end

endmodule
